// File: sv/salc_pkg.sv
package salc_pkg;

  localparam int MAX_SET_BITS = 8;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_BITS    = 48;

  localparam int NUM_SETS   = 1 << MAX_SET_BITS;
  localparam int WAY_BITS   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TREE_N     = 1 << WAY_BITS;
  localparam int SB_W       = $clog2(MAX_SET_BITS + 1);
  localparam int NW_W       = $clog2(MAX_WAYS + 1);
  localparam int SHAMT_W    = $clog2(31 + MAX_SET_BITS + 1);
  localparam int STAMP_BITS = 32;
  localparam int CNT_BITS   = 32;
  localparam int PADDR_BITS = 4;
  localparam int PDATA_BITS = 32;

  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    ACT_FETCH  = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_STORE  = 2'd2,
    ACT_MODIFY = 2'd3
  } action_t;

  localparam logic [1:0] REG_SET_BITS    = 2'd0;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS        = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [SB_W-1:0] sb;
    logic [4:0]      bo;
    logic [NW_W-1:0] nw;
  } cfg_t;

  typedef struct packed {
    logic [MAX_WAYS-1:0]                 valid;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  tag;
    logic [MAX_WAYS-1:0][STAMP_BITS-1:0] stamp;
  } row_t;

  typedef struct packed {
    logic                hit;
    logic [WAY_BITS-1:0] hit_way;
    logic                inv_found;
    logic [WAY_BITS-1:0] inv_way;
    logic [WAY_BITS-1:0] victim_way;
  } dec_t;

  typedef struct packed {
    logic                was_hit;
    logic                was_miss;
    logic                was_evict;
    logic                second_hit;
    logic [CNT_BITS-1:0] hit_total;
    logic [CNT_BITS-1:0] miss_total;
    logic [CNT_BITS-1:0] evict_total;
    logic                stamp_saturated;
  } res_t;

  function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] v,
                                                  input logic [1:0] inc);
    logic [CNT_BITS:0] s;
    s = {1'b0, v} + (CNT_BITS + 1)'(inc);
    return s[CNT_BITS] ? CNT_MAX : s[CNT_BITS-1:0];
  endfunction

  function automatic logic [ADDR_BITS-1:0] tag_of(input logic [ADDR_BITS-1:0] a,
                                                  input cfg_t c);
    logic [SHAMT_W-1:0] sh;
    sh = SHAMT_W'(c.bo) + SHAMT_W'(c.sb);
    return a >> sh;
  endfunction

  function automatic logic [MAX_SET_BITS-1:0] set_of(input logic [ADDR_BITS-1:0] a,
                                                     input cfg_t c);
    logic [ADDR_BITS-1:0]    s;
    logic [MAX_SET_BITS-1:0] m;
    s = a >> c.bo;
    for (int i = 0; i < MAX_SET_BITS; i++) begin
      m[i] = (SB_W'(i) < c.sb);
    end
    return s[MAX_SET_BITS-1:0] & m;
  endfunction

endpackage

// File: sv/salc_channels.sv
interface salc_in_if;
  import salc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [ADDR_BITS-1:0] address;

  modport source (output valid, action, address, input ready);
  modport sink (input valid, action, address, output ready);
endinterface

interface salc_out_if;
  import salc_pkg::*;

  logic                valid;
  logic                ready;
  logic                was_hit;
  logic                was_miss;
  logic                was_evict;
  logic                second_hit;
  logic [CNT_BITS-1:0] hit_total;
  logic [CNT_BITS-1:0] miss_total;
  logic [CNT_BITS-1:0] evict_total;
  logic                stamp_saturated;

  modport source (output valid, was_hit, was_miss, was_evict, second_hit, hit_total,
                  miss_total, evict_total, stamp_saturated, input ready);
  modport sink (input valid, was_hit, was_miss, was_evict, second_hit, hit_total,
                miss_total, evict_total, stamp_saturated, output ready);
endinterface

// File: sv/salc_cfg_regs.sv
module salc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [salc_pkg::PADDR_BITS-1:0] paddr,
  input  logic [salc_pkg::PDATA_BITS-1:0] pwdata,
  output logic [salc_pkg::PDATA_BITS-1:0] prdata,
  output logic                            pready,
  output salc_pkg::cfg_t                  cfg
);
  import salc_pkg::*;

  logic [3:0] set_bits_r;
  logic [4:0] offset_bits_r;
  logic [3:0] ways_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= 4'd4;
      offset_bits_r <= 5'd4;
      ways_r        <= 4'd1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_SET_BITS:    set_bits_r    <= pwdata[3:0];
        REG_OFFSET_BITS: offset_bits_r <= pwdata[4:0];
        REG_WAYS:        ways_r        <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SET_BITS:    prdata = PDATA_BITS'(set_bits_r);
      REG_OFFSET_BITS: prdata = PDATA_BITS'(offset_bits_r);
      REG_WAYS:        prdata = PDATA_BITS'(ways_r);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    cfg.bo = offset_bits_r;
    if ({1'b0, set_bits_r} > 5'(MAX_SET_BITS)) begin
      cfg.sb = SB_W'(MAX_SET_BITS);
    end else begin
      cfg.sb = SB_W'(set_bits_r);
    end
    if (ways_r == 4'd0) begin
      cfg.nw = NW_W'(1);
    end else if ({1'b0, ways_r} > 5'(MAX_WAYS)) begin
      cfg.nw = NW_W'(MAX_WAYS);
    end else begin
      cfg.nw = NW_W'(ways_r);
    end
  end

endmodule

// File: sv/salc_set_ram.sv
module salc_set_ram (
  input  logic                              clk,
  input  logic                              we,
  input  logic [salc_pkg::MAX_SET_BITS-1:0] waddr,
  input  salc_pkg::row_t                    wdata,
  input  logic                              re,
  input  logic [salc_pkg::MAX_SET_BITS-1:0] raddr,
  output salc_pkg::row_t                    rdata
);
  import salc_pkg::*;

  row_t mem [NUM_SETS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/salc_way_sel.sv
module salc_way_sel (
  input  salc_pkg::row_t                 row,
  input  logic [salc_pkg::ADDR_BITS-1:0] tag,
  input  logic [salc_pkg::NW_W-1:0]      nw,
  output salc_pkg::dec_t                 dec
);
  import salc_pkg::*;

  logic [TREE_N-1:0]   active;
  logic                node_ok    [2*TREE_N];
  logic [STAMP_BITS-1:0] node_stamp [2*TREE_N];
  logic [WAY_BITS-1:0] node_way   [2*TREE_N];

  always_comb begin
    for (int w = 0; w < TREE_N; w++) begin
      active[w] = (w < MAX_WAYS) && (NW_W'(w) < nw);
    end
  end

  always_comb begin
    dec.hit       = 1'b0;
    dec.hit_way   = '0;
    dec.inv_found = 1'b0;
    dec.inv_way   = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (active[w] && row.valid[w] && (row.tag[w] == tag)) begin
        dec.hit     = 1'b1;
        dec.hit_way = WAY_BITS'(w);
      end
      if (active[w] && !row.valid[w]) begin
        dec.inv_found = 1'b1;
        dec.inv_way   = WAY_BITS'(w);
      end
    end
  end

  always_comb begin
    node_ok[0]    = 1'b0;
    node_stamp[0] = '0;
    node_way[0]   = '0;
    for (int w = 0; w < TREE_N; w++) begin
      node_ok[TREE_N + w]  = active[w];
      node_way[TREE_N + w] = WAY_BITS'(w);
      if (w < MAX_WAYS) begin
        node_stamp[TREE_N + w] = row.stamp[w];
      end else begin
        node_stamp[TREE_N + w] = '0;
      end
    end
    for (int n = TREE_N - 1; n >= 1; n--) begin
      if (node_ok[2*n] && (!node_ok[2*n+1] || node_stamp[2*n] <= node_stamp[2*n+1])) begin
        node_ok[n]    = node_ok[2*n];
        node_stamp[n] = node_stamp[2*n];
        node_way[n]   = node_way[2*n];
      end else begin
        node_ok[n]    = node_ok[2*n+1];
        node_stamp[n] = node_stamp[2*n+1];
        node_way[n]   = node_way[2*n+1];
      end
    end
    dec.victim_way = node_way[1];
  end

endmodule

// File: sv/set_assoc_lru_cache_sim_unit.sv
// Tag-only set-associative cache with LRU replacement, one trace record per
// transaction.
// in_ch carries action and address; out_ch returns one result per record:
// hit, miss and evict flags for the first lookup, the modify second-lookup
// flag, saturating running totals and the stamp-saturated flag.
// Configuration registers (set bits, offset bits, ways) sit on the APB port
// at byte addresses 0, 4 and 8; write them only while the unit is idle.
// Each record does one read of its set row in the set RAM, and all but
// a fetch write it back: accept, row read and way compare, write-back.
// A result is registered on out_ch in the write-back step, and a new
// record is taken only once the previous one has left that step.
// A modify needs no second pass: its second lookup always hits the line
// just touched.
// After reset the unit sweeps the set RAM, clearing one row per cycle, over
// all 256 sets before in_ch.ready first rises.
// When out_ch stalls, the unit still accepts and looks up the next record,
// then holds before write-back until the waiting result is taken.
module set_assoc_lru_cache_sim_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  salc_in_if.sink                         in_ch,
  salc_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [salc_pkg::PADDR_BITS-1:0] paddr,
  input  logic [salc_pkg::PDATA_BITS-1:0] pwdata,
  output logic [salc_pkg::PDATA_BITS-1:0] prdata,
  output logic                            pready
);
  import salc_pkg::*;

  cfg_t                    cfg;
  state_t                  state_r, state_nxt;
  logic [MAX_SET_BITS-1:0] clr_idx_r;
  logic [1:0]              action_r;
  logic [MAX_SET_BITS-1:0] set_r;
  logic [ADDR_BITS-1:0]    tag_r;
  dec_t                    dec, dec_r;
  row_t                    rd_row, wr_row, upd_row;
  logic                    ram_we, ram_re;
  logic [MAX_SET_BITS-1:0] ram_waddr, ram_raddr;
  logic [CNT_BITS-1:0]     rec_cnt_r, hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic [CNT_BITS-1:0]     rec_cnt_nxt, hit_cnt_nxt, miss_cnt_nxt, evict_cnt_nxt;
  logic                    out_valid_r;
  res_t                    res_r, res_nxt;
  logic                    in_fire, upd_go, upd_fire, act_on, is_modify, last_clr;
  logic [WAY_BITS-1:0]     tgt_way;

  salc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  salc_set_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_row),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_row)
  );

  salc_way_sel u_sel (
    .row (rd_row),
    .tag (tag_r),
    .nw  (cfg.nw),
    .dec (dec)
  );

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign upd_go    = !out_valid_r || out_ch.ready;
  assign upd_fire  = (state_r == ST_UPDATE) && upd_go;
  assign act_on    = (action_r != ACT_FETCH);
  assign is_modify = (action_r == ACT_MODIFY);
  assign last_clr  = (clr_idx_r == MAX_SET_BITS'(NUM_SETS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (last_clr) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_UPDATE;
      ST_UPDATE: if (upd_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = set_r;
    wr_row      = upd_row;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        wr_row    = '0;
      end
      ST_IDLE:   in_ch.ready = 1'b1;
      ST_LOOKUP: ;
      ST_UPDATE: ram_we = upd_go && act_on;
      default: ;
    endcase
  end

  assign ram_re    = in_fire;
  assign ram_raddr = set_of(in_ch.address, cfg);

  always_comb begin
    if (dec_r.hit) begin
      tgt_way = dec_r.hit_way;
    end else if (dec_r.inv_found) begin
      tgt_way = dec_r.inv_way;
    end else begin
      tgt_way = dec_r.victim_way;
    end
    upd_row                = rd_row;
    upd_row.valid[tgt_way] = 1'b1;
    upd_row.tag[tgt_way]   = tag_r;
    upd_row.stamp[tgt_way] = rec_cnt_r;
  end

  always_comb begin
    if (act_on) begin
      hit_cnt_nxt   = sat_add(hit_cnt_r, {1'b0, dec_r.hit} + {1'b0, is_modify});
      miss_cnt_nxt  = sat_add(miss_cnt_r, {1'b0, !dec_r.hit});
      evict_cnt_nxt = sat_add(evict_cnt_r, {1'b0, !dec_r.hit && !dec_r.inv_found});
      rec_cnt_nxt   = sat_add(rec_cnt_r, 2'd1);
    end else begin
      hit_cnt_nxt   = hit_cnt_r;
      miss_cnt_nxt  = miss_cnt_r;
      evict_cnt_nxt = evict_cnt_r;
      rec_cnt_nxt   = rec_cnt_r;
    end
    res_nxt.was_hit         = act_on && dec_r.hit;
    res_nxt.was_miss        = act_on && !dec_r.hit;
    res_nxt.was_evict       = act_on && !dec_r.hit && !dec_r.inv_found;
    res_nxt.second_hit      = is_modify;
    res_nxt.hit_total       = hit_cnt_nxt;
    res_nxt.miss_total      = miss_cnt_nxt;
    res_nxt.evict_total     = evict_cnt_nxt;
    res_nxt.stamp_saturated = (rec_cnt_nxt == CNT_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      rec_cnt_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + MAX_SET_BITS'(1);
      end
      if (upd_fire) begin
        out_valid_r <= 1'b1;
        rec_cnt_r   <= rec_cnt_nxt;
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        evict_cnt_r <= evict_cnt_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      action_r <= in_ch.action;
      set_r    <= set_of(in_ch.address, cfg);
      tag_r    <= tag_of(in_ch.address, cfg);
    end
    if (state_r == ST_LOOKUP) begin
      dec_r <= dec;
    end
    if (upd_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.was_hit         = res_r.was_hit;
  assign out_ch.was_miss        = res_r.was_miss;
  assign out_ch.was_evict       = res_r.was_evict;
  assign out_ch.second_hit      = res_r.second_hit;
  assign out_ch.hit_total       = res_r.hit_total;
  assign out_ch.miss_total      = res_r.miss_total;
  assign out_ch.evict_total     = res_r.evict_total;
  assign out_ch.stamp_saturated = res_r.stamp_saturated;

endmodule

// File: dv/salc_cache_checker.sv
`timescale 1ns / 1ps
module salc_cache_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  salc_in_if                              in_mon,
  salc_out_if                             out_mon,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [salc_pkg::PADDR_BITS-1:0] paddr,
  input  logic [salc_pkg::PDATA_BITS-1:0] pwdata,
  output int                              fail_count,
  output int                              pending
);
  import salc_pkg::*;

  localparam int NUM_LINES = NUM_SETS * MAX_WAYS;

  typedef enum {LK_HIT, LK_FILL, LK_EVICT} lookup_t;

  logic [3:0]           sb_reg;
  logic [4:0]           bo_reg;
  logic [3:0]           nw_reg;
  logic                 way_valid [NUM_LINES];
  logic [ADDR_BITS-1:0] way_tag   [NUM_LINES];
  logic [31:0]          way_stamp [NUM_LINES];
  logic [31:0]          record_ctr;
  logic [31:0]          hit_ctr;
  logic [31:0]          miss_ctr;
  logic [31:0]          evict_ctr;
  res_t                 result_fifo [$];
  int                   result_no;

  initial fail_count = 0;

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic lookup_t probe_line(input logic [ADDR_BITS-1:0] a);
    int                   sbits;
    int                   ways;
    int                   base;
    int                   victim;
    logic [ADDR_BITS-1:0] tg;
    logic [ADDR_BITS-1:0] idx;
    sbits = (sb_reg > MAX_SET_BITS) ? MAX_SET_BITS : int'(sb_reg);
    ways  = (nw_reg == 0) ? 1 : ((nw_reg > MAX_WAYS) ? MAX_WAYS : int'(nw_reg));
    tg    = a >> (int'(bo_reg) + sbits);
    idx   = (a >> bo_reg) & ((ADDR_BITS'(1) << sbits) - ADDR_BITS'(1));
    base  = int'(idx) * MAX_WAYS;
    for (int w = 0; w < ways; w++) begin
      if (way_valid[base + w] && way_tag[base + w] == tg) begin
        way_stamp[base + w] = record_ctr;
        hit_ctr = bump(hit_ctr);
        return LK_HIT;
      end
    end
    miss_ctr = bump(miss_ctr);
    for (int w = 0; w < ways; w++) begin
      if (!way_valid[base + w]) begin
        way_valid[base + w] = 1'b1;
        way_tag[base + w]   = tg;
        way_stamp[base + w] = record_ctr;
        return LK_FILL;
      end
    end
    evict_ctr = bump(evict_ctr);
    victim = 0;
    for (int w = 1; w < ways; w++) begin
      if (way_stamp[base + w] < way_stamp[base + victim]) victim = w;
    end
    way_tag[base + victim]   = tg;
    way_stamp[base + victim] = record_ctr;
    return LK_EVICT;
  endfunction

  function automatic res_t predict_record(input logic [1:0] act,
                                          input logic [ADDR_BITS-1:0] a);
    res_t    r;
    lookup_t first;
    r = '0;
    if (act != ACT_FETCH) begin
      first       = probe_line(a);
      r.was_hit   = (first == LK_HIT);
      r.was_miss  = (first != LK_HIT);
      r.was_evict = (first == LK_EVICT);
      if (act == ACT_MODIFY) r.second_hit = (probe_line(a) == LK_HIT);
      record_ctr = bump(record_ctr);
    end
    r.hit_total       = hit_ctr;
    r.miss_total      = miss_ctr;
    r.evict_total     = evict_ctr;
    r.stamp_saturated = (record_ctr == 32'hFFFF_FFFF);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < 100) $display("MISMATCH result %0d: %s", result_no, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      sb_reg     = 4'd4;
      bo_reg     = 5'd4;
      nw_reg     = 4'd1;
      record_ctr = '0;
      hit_ctr    = '0;
      miss_ctr   = '0;
      evict_ctr  = '0;
      result_no  = 0;
      foreach (way_valid[i]) way_valid[i] = 1'b0;
      result_fifo.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_BITS-1:2])
          REG_SET_BITS:    sb_reg = pwdata[3:0];
          REG_OFFSET_BITS: bo_reg = pwdata[4:0];
          REG_WAYS:        nw_reg = pwdata[3:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (result_fifo.size() == 0) begin
          report_mismatch("result with no record outstanding");
        end else begin
          want = result_fifo.pop_front();
          compare_field("was_hit", 32'(out_mon.was_hit), 32'(want.was_hit));
          compare_field("was_miss", 32'(out_mon.was_miss), 32'(want.was_miss));
          compare_field("was_evict", 32'(out_mon.was_evict), 32'(want.was_evict));
          compare_field("second_hit", 32'(out_mon.second_hit), 32'(want.second_hit));
          compare_field("hit_total", out_mon.hit_total, want.hit_total);
          compare_field("miss_total", out_mon.miss_total, want.miss_total);
          compare_field("evict_total", out_mon.evict_total, want.evict_total);
          compare_field("stamp_saturated", 32'(out_mon.stamp_saturated),
                        32'(want.stamp_saturated));
        end
        result_no++;
      end
      if (in_mon.valid && in_mon.ready) begin
        result_fifo.push_back(predict_record(in_mon.action, in_mon.address));
      end
      pending <= result_fifo.size();
    end
  end

endmodule

// File: dv/set_assoc_lru_cache_sim_unit_test.sv
`timescale 1ns / 1ps
module set_assoc_lru_cache_sim_unit_test;
  import salc_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_RECORDS = 220;

  typedef enum {RX_OPEN, RX_CHOPPY, RX_SPARSE} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;
  int                    cycle_count = 0;
  bit                    hold_req = 1'b0;
  int                    cur_sb;
  int                    cur_bo;
  int                    cur_ways;

  salc_in_if  in_ch();
  salc_out_if out_ch();

  set_assoc_lru_cache_sim_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  salc_cache_checker lru_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stall segments, plus a long hold-off on request
  initial begin : receiver
    rx_mode_t mode;
    int       seg_left;
    out_ch.ready <= 1'b0;
    seg_left = 0;
    mode     = RX_OPEN;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(5, 60);
          mode     = rx_mode_t'($urandom_range(0, 2));
        end
        seg_left--;
        case (mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_CHOPPY: out_ch.ready <= ($urandom_range(0, 1) == 1);
          default:   out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic apply_config(input int sb, input int bo, input int ways);
    while (!in_ch.ready) @(posedge clk);
    reg_write(REG_SET_BITS, 32'(sb));
    reg_write(REG_OFFSET_BITS, 32'(bo));
    reg_write(REG_WAYS, 32'(ways));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_sb   = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
    cur_bo   = bo;
    cur_ways = (ways == 0) ? 1 : ((ways > MAX_WAYS) ? MAX_WAYS : ways);
  endtask

  task automatic offer(input action_t act, input logic [ADDR_BITS-1:0] a);
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.address <= a;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold the input until every outstanding result has been taken
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic action_t pick_action();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2) return ACT_FETCH;
    if (r < 7) return ACT_LOAD;
    if (r < 12) return ACT_STORE;
    return ACT_MODIFY;
  endfunction

  // mostly a small pool of tags and sets so lines collide, sometimes anything
  function automatic logic [ADDR_BITS-1:0] pick_addr();
    logic [63:0]          r;
    logic [ADDR_BITS-1:0] a;
    int                   set_span;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) return r[ADDR_BITS-1:0];
    set_span = ($urandom_range(0, 3) == 0) ? (1 << cur_sb) - 1 : 2;
    a = (ADDR_BITS'($urandom_range(0, 2 * cur_ways)) << (cur_bo + cur_sb))
      | (ADDR_BITS'($urandom_range(0, set_span)) << cur_bo)
      | (r[ADDR_BITS-1:0] & ((ADDR_BITS'(1) << cur_bo) - ADDR_BITS'(1)));
    return a;
  endfunction

  task automatic run_phase(input int records, input bit long_hold);
    int      sent;
    int      burst;
    action_t act;
    sent = 0;
    if (long_hold) hold_req = 1'b1;
    while (sent < records) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        act = pick_action();
        offer(act, pick_addr());
        if (act != ACT_FETCH) sent++;
      end
      idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
    end
    drain();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.action  <= ACT_FETCH;
    in_ch.address <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    cur_sb   = 4;
    cur_bo   = 4;
    cur_ways = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);

    // reset configuration: direct-mapped, 16 sets, 16-byte blocks
    offer(ACT_FETCH, 48'h0);
    offer(ACT_LOAD, 48'h0);
    offer(ACT_LOAD, 48'h8);
    offer(ACT_STORE, 48'h10);
    offer(ACT_MODIFY, 48'h10);
    offer(ACT_MODIFY, 48'h12345);
    offer(ACT_LOAD, 48'h100);
    offer(ACT_LOAD, 48'h0);
    offer(ACT_LOAD, 48'hFFFF_FFFF_FFFF);
    offer(ACT_STORE, 48'hFFFF_FFFF_FFFF);
    offer(ACT_FETCH, 48'hFFFF_FFFF_FFFF);
    offer(ACT_MODIFY, 48'h8000_0000_0000);
    offer(ACT_LOAD, 48'h5555_5555_5555);
    offer(ACT_STORE, 48'hAAAA_AAAA_AAAA);
    drain();

    // single set, no offset, ways of zero taken as one
    apply_config(0, 0, 0);
    offer(ACT_LOAD, 48'h0);
    offer(ACT_LOAD, 48'h1);
    offer(ACT_MODIFY, 48'h1);
    offer(ACT_STORE, 48'hFFFF_FFFF_FFFF);
    drain();

    // settings above range are clamped
    apply_config(15, 31, 15);
    offer(ACT_LOAD, 48'h0);
    offer(ACT_LOAD, 48'h80_0000_0000);
    offer(ACT_MODIFY, 48'hFFFF_FFFF_FFFF);
    drain();

    run_phase(PHASE_RECORDS, 1'b0);
    apply_config(0, 0, 0);
    run_phase(PHASE_RECORDS, 1'b0);
    apply_config(8, 16, 8);
    run_phase(PHASE_RECORDS, 1'b1);
    apply_config(1, 1, 2);
    run_phase(PHASE_RECORDS, 1'b0);
    apply_config(3, 6, 4);
    run_phase(PHASE_RECORDS, 1'b0);
    apply_config(4, 4, 1);
    run_phase(PHASE_RECORDS, 1'b0);
    repeat (3) begin
      apply_config($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 15));
      run_phase(PHASE_RECORDS, 1'b0);
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
